// File: src/ps2kt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ps2kt_pkg;

    localparam int CODE_W     = 8;
    localparam int KEY_W      = 9;
    localparam int MOD_W      = 8;
    localparam int ROW_BITS   = 8;
    localparam int ROW_SEL_W  = 3;
    localparam int ROWS       = 64;
    localparam int ROW_ADDR_W = 6;
    localparam int SKIP_W     = 3;
    localparam int RES_W      = KEY_W + 2 + MOD_W;
    localparam int TDATA_OUT_W = 24;

    localparam logic [SKIP_W-1:0] PAUSE_SKIP = 3'd7;

    localparam logic [CODE_W-1:0] CODE_EXT   = 8'hE0;
    localparam logic [CODE_W-1:0] CODE_REL   = 8'hF0;
    localparam logic [CODE_W-1:0] CODE_PAUSE = 8'hE1;
    localparam logic [CODE_W-1:0] CODE_FAKE  = 8'h12;

    // LCtrl, LShift, LAlt, LGui, RCtrl, RShift, RAlt, RGui
    localparam logic [KEY_W-1:0] MOD_KEYS [MOD_W] = '{
        9'h014, 9'h012, 9'h011, 9'h11F, 9'h114, 9'h059, 9'h111, 9'h127
    };

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_REL    = 3'd1,
        ST_EXT    = 3'd2,
        ST_EXTREL = 3'd3,
        ST_SKIP   = 3'd4
    } decode_state_t;

    typedef struct packed {
        logic [MOD_W-1:0] modifiers;
        logic             map_changed;
        logic             key_down;
        logic [KEY_W-1:0] key_index;
    } result_t;

endpackage

`default_nettype wire

// File: src/ps2kt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ps2kt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// File: src/ps2_scancode_key_tracker_core.sv
// PS/2 set-2 scan code key tracker.
// Input stream s_*: one scan code byte per item in s_tdata[7:0].
// Output stream m_*: one result item per input byte:
//   key_index[8:0], key_down[9], map_changed[10], modifiers[18:11].
// Key-down map is 64 rows x 8 bits in block RAM, read-modify-write with
// forwarding of the last row written.
// Path: an accepted byte is registered into the s1_* stage as its map row
// is read, then written into the output buffer that drives m_tvalid.
// Throughput: one item per cycle while m_tready stays high.
// Reset: decode state, modifier bits and the output queue clear at once;
// then a pass zeroes all 64 map RAM rows, one row per cycle, with
// s_tready low.
// Stall: results queue in a three-entry output buffer; outside the clear
// pass, s_tready drops only when that buffer plus the item in flight would
// overflow, and depends on registers only.
`timescale 1ns / 1ps
`default_nettype none

module ps2_scancode_key_tracker_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // scan_code[7:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // key_index[8:0], key_down[9],
                                        // map_changed[10], modifiers[18:11]
);

    import ps2kt_pkg::*;

    logic                  s_accept;
    logic                  m_accept;

    decode_state_t         state_reg, state_next;
    logic [SKIP_W-1:0]     skip_reg, skip_next;
    logic [KEY_W-1:0]      key0;
    logic                  down0;
    logic                  event0;
    logic [CODE_W-1:0]     code;

    logic                  s1_valid_reg;
    logic [KEY_W-1:0]      s1_key_reg;
    logic                  s1_down_reg;
    logic                  s1_event_reg;

    logic                  clr_busy_reg;
    logic [ROW_ADDR_W-1:0] clr_cnt_reg;

    logic                  ram_we;
    logic [ROW_ADDR_W-1:0] ram_waddr;
    logic [ROW_BITS-1:0]   ram_wdata;
    logic [ROW_BITS-1:0]   ram_rdata;

    logic                  last_wr_valid_reg;
    logic [ROW_ADDR_W-1:0] last_wr_row_reg;
    logic [ROW_BITS-1:0]   last_wr_data_reg;

    logic [ROW_BITS-1:0]   row_data;
    logic [ROW_BITS-1:0]   row_new;
    logic                  old_bit;
    logic                  changed1;
    logic                  key_write;

    logic [MOD_W-1:0]      mod_reg, mod_next;
    result_t               result1;

    result_t               fifo_reg [3];
    logic [1:0]            wr_ptr_reg, rd_ptr_reg;
    logic [1:0]            cnt_reg;
    logic [2:0]            in_flight;

    assign code     = s_tdata[CODE_W-1:0];
    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid && m_tready;

    assign in_flight = {1'b0, cnt_reg} + {2'b00, s1_valid_reg};
    assign s_tready  = !clr_busy_reg && (in_flight <= 3'd2);

    // decoder
    always_comb
    begin
        state_next = state_reg;
        skip_next  = skip_reg;
        key0       = '0;
        down0      = 1'b0;
        event0     = 1'b0;
        if (s_accept)
        begin
            case (state_reg)
                ST_REL:
                begin
                    key0       = {1'b0, code};
                    event0     = 1'b1;
                    state_next = ST_IDLE;
                end
                ST_EXT:
                begin
                    if (code == CODE_REL)
                    begin
                        state_next = ST_EXTREL;
                    end
                    else
                    begin
                        key0       = {1'b1, code};
                        down0      = 1'b1;
                        event0     = (code != CODE_FAKE);
                        state_next = ST_IDLE;
                    end
                end
                ST_EXTREL:
                begin
                    key0       = {1'b1, code};
                    event0     = (code != CODE_FAKE);
                    state_next = ST_IDLE;
                end
                ST_SKIP:
                begin
                    if (skip_reg <= 3'd1)
                    begin
                        skip_next  = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        skip_next = skip_reg - 3'd1;
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                    if (code == CODE_EXT)
                    begin
                        state_next = ST_EXT;
                    end
                    else if (code == CODE_REL)
                    begin
                        state_next = ST_REL;
                    end
                    else if (code == CODE_PAUSE)
                    begin
                        state_next = ST_SKIP;
                        skip_next  = PAUSE_SKIP;
                    end
                    else
                    begin
                        key0   = {1'b0, code};
                        down0  = 1'b1;
                        event0 = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            skip_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            skip_reg     <= skip_next;
            s1_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_key_reg   <= key0;
            s1_down_reg  <= down0;
            s1_event_reg <= event0;
        end
    end

    // map update
    assign row_data = (last_wr_valid_reg && last_wr_row_reg == s1_key_reg[KEY_W-1:ROW_SEL_W])
                      ? last_wr_data_reg : ram_rdata;
    assign old_bit  = row_data[s1_key_reg[ROW_SEL_W-1:0]];
    assign changed1 = s1_event_reg && (old_bit != s1_down_reg);
    assign key_write = s1_valid_reg && changed1;

    always_comb
    begin
        row_new = row_data;
        row_new[s1_key_reg[ROW_SEL_W-1:0]] = s1_down_reg;
    end

    assign ram_we    = clr_busy_reg || key_write;
    assign ram_waddr = clr_busy_reg ? clr_cnt_reg : s1_key_reg[KEY_W-1:ROW_SEL_W];
    assign ram_wdata = clr_busy_reg ? '0 : row_new;

    ps2kt_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (ROWS)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (s_accept),
        .raddr (key0[KEY_W-1:ROW_SEL_W]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg      <= 1'b1;
            clr_cnt_reg       <= '0;
            last_wr_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + ROW_ADDR_W'(1);
                if (clr_cnt_reg == ROW_ADDR_W'(ROWS - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (ram_we)
            begin
                last_wr_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            last_wr_row_reg  <= ram_waddr;
            last_wr_data_reg <= ram_wdata;
        end
    end

    // modifier mirror
    always_comb
    begin
        mod_next = mod_reg;
        for (int i = 0; i < MOD_W; i++)
        begin
            if (key_write && s1_key_reg == MOD_KEYS[i])
            begin
                mod_next[i] = s1_down_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg <= '0;
        end
        else
        begin
            mod_reg <= mod_next;
        end
    end

    assign result1.key_index   = s1_key_reg;
    assign result1.key_down    = s1_down_reg;
    assign result1.map_changed = changed1;
    assign result1.modifiers   = mod_next;

    // output buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (s1_valid_reg)
            begin
                wr_ptr_reg <= (wr_ptr_reg == 2'd2) ? 2'd0 : wr_ptr_reg + 2'd1;
            end
            if (m_accept)
            begin
                rd_ptr_reg <= (rd_ptr_reg == 2'd2) ? 2'd0 : rd_ptr_reg + 2'd1;
            end
            if (s1_valid_reg && !m_accept)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (!s1_valid_reg && m_accept)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            fifo_reg[wr_ptr_reg] <= result1;
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = {(TDATA_OUT_W - RES_W)'(0), fifo_reg[rd_ptr_reg]};

endmodule

`default_nettype wire

// File: tb/ps2_scancode_key_tracker_core_tb.sv
`timescale 1ns / 1ps

module ps2_scancode_key_tracker_core_tb;

    import ps2kt_pkg::*;

    localparam int RANDOM_ITEMS = 1650;
    localparam int STALL_LIMIT  = 2000;
    localparam int RX_HOLD      = 300;
    localparam int RX_HOLD_AT   = 1200;
    localparam int DRAIN_AT     = 900;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              typed;
        result_t           want;
    } dir_row_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    // predictor state
    decode_state_t dec_st;
    logic [SKIP_W-1:0] skip_left;
    logic [511:0] keys_down;

    result_t pending_results [$];
    dir_row_t dir_rows [25];

    int  bytes_sent;
    int  results_seen;
    int  map_changes;
    int  mismatches;
    int  stall_cycles;
    int  hold_left;
    bit  held;
    bit  steady;
    result_t got;
    result_t want;

    logic [CODE_W-1:0] hot_codes [11] = '{
        8'h14, 8'h12, 8'h11, 8'h1F, 8'h27, 8'h59, 8'h00, 8'hFF, 8'hE0, 8'hF0, 8'hE1
    };

    ps2_scancode_key_tracker_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic result_t decode_byte(input logic [CODE_W-1:0] code);
        result_t r;
        logic    hit;
        r   = '0;
        hit = 1'b0;
        case (dec_st)
            ST_REL:
            begin
                r.key_index = {1'b0, code};
                hit = 1'b1;
                dec_st = ST_IDLE;
            end
            ST_EXT:
            begin
                if (code == CODE_REL)
                    dec_st = ST_EXTREL;
                else
                begin
                    r.key_index = {1'b1, code};
                    r.key_down = 1'b1;
                    hit = (code != CODE_FAKE);
                    dec_st = ST_IDLE;
                end
            end
            ST_EXTREL:
            begin
                r.key_index = {1'b1, code};
                hit = (code != CODE_FAKE);
                dec_st = ST_IDLE;
            end
            ST_SKIP:
            begin
                if (skip_left <= 1)
                begin
                    skip_left = '0;
                    dec_st = ST_IDLE;
                end
                else
                    skip_left = skip_left - 1'b1;
            end
            default:
            begin
                dec_st = ST_IDLE;
                if (code == CODE_EXT)
                    dec_st = ST_EXT;
                else if (code == CODE_REL)
                    dec_st = ST_REL;
                else if (code == CODE_PAUSE)
                begin
                    dec_st = ST_SKIP;
                    skip_left = PAUSE_SKIP;
                end
                else
                begin
                    r.key_index = {1'b0, code};
                    r.key_down = 1'b1;
                    hit = 1'b1;
                end
            end
        endcase
        if (hit && keys_down[r.key_index] != r.key_down)
        begin
            keys_down[r.key_index] = r.key_down;
            r.map_changed = 1'b1;
        end
        for (int i = 0; i < MOD_W; i++)
            r.modifiers[i] = keys_down[MOD_KEYS[i]];
        return r;
    endfunction

    function automatic dir_row_t row(input logic [CODE_W-1:0] c, input logic t,
                                     input logic [KEY_W-1:0] k, input logic d,
                                     input logic ch, input logic [MOD_W-1:0] m);
        return {c, t, m, ch, d, k};
    endfunction

    task automatic send_byte(input logic [CODE_W-1:0] code, input logic typed,
                             input result_t typed_want);
        result_t r;
        while (!steady && $urandom_range(0, 99) < 36)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = decode_byte(code);
        pending_results.push_back(typed ? typed_want : r);
        bytes_sent++;
    endtask

    task automatic send_code(input logic [CODE_W-1:0] code);
        send_byte(code, 1'b0, '0);
    endtask

    function automatic logic [CODE_W-1:0] pick_code();
        if ($urandom_range(0, 1) == 0)
            return hot_codes[$urandom_range(0, 10)];
        return CODE_W'($urandom_range(0, 255));
    endfunction

    // result checker and receiver backpressure
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[RES_W-1:0];
            results_seen++;
            if (got.map_changed)
                map_changes++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result: key %03h down %0b chg %0b mods %02h",
                             $time, got.key_index, got.key_down, got.map_changed,
                             got.modifiers);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.key_index !== want.key_index || got.key_down !== want.key_down
                    || got.map_changed !== want.map_changed
                    || got.modifiers !== want.modifiers || m_tdata[23:RES_W] !== '0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"[%0t] result %0d mismatch: exp key %03h down %0b chg %0b ",
                                  "mods %02h, got key %03h down %0b chg %0b mods %02h pad %02h"},
                                 $time, results_seen, want.key_index, want.key_down,
                                 want.map_changed, want.modifiers, got.key_index,
                                 got.key_down, got.map_changed, got.modifiers,
                                 m_tdata[23:RES_W]);
                end
            end
        end
        if (!held && results_seen >= RX_HOLD_AT)
        begin
            held = 1'b1;
            hold_left = RX_HOLD;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= steady || ($urandom_range(0, 99) >= 36);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[%0t] no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("** ps2_scancode_key_tracker_core: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int kind;
        bit drained;
        logic [CODE_W-1:0] code;

        dec_st    = ST_IDLE;
        skip_left = '0;
        keys_down = '0;
        drained   = 1'b0;

        dir_rows[0]  = row(8'h00, 1, 9'h000, 1, 1, 8'h00);
        dir_rows[1]  = row(8'hFF, 1, 9'h0FF, 1, 1, 8'h00);
        dir_rows[2]  = row(8'h14, 1, 9'h014, 1, 1, 8'h01);
        dir_rows[3]  = row(CODE_EXT, 1, 9'h000, 0, 0, 8'h01);
        dir_rows[4]  = row(8'h27, 0, 0, 0, 0, 0);        // right gui press
        dir_rows[5]  = row(CODE_EXT, 0, 0, 0, 0, 0);
        dir_rows[6]  = row(CODE_FAKE, 0, 0, 0, 0, 0);    // fake shift press
        dir_rows[7]  = row(CODE_EXT, 0, 0, 0, 0, 0);
        dir_rows[8]  = row(CODE_REL, 0, 0, 0, 0, 0);
        dir_rows[9]  = row(CODE_FAKE, 0, 0, 0, 0, 0);    // fake shift release
        dir_rows[10] = row(8'h14, 0, 0, 0, 0, 0);        // repeated press
        dir_rows[11] = row(CODE_REL, 0, 0, 0, 0, 0);
        dir_rows[12] = row(8'h14, 0, 0, 0, 0, 0);
        dir_rows[13] = row(CODE_REL, 0, 0, 0, 0, 0);
        dir_rows[14] = row(CODE_EXT, 0, 0, 0, 0, 0);     // prefix taken as key code
        dir_rows[15] = row(CODE_EXT, 0, 0, 0, 0, 0);
        dir_rows[16] = row(CODE_EXT, 0, 0, 0, 0, 0);     // extended 0xE0 press
        dir_rows[17] = row(CODE_PAUSE, 1, 9'h000, 0, 0, 8'h80);
        dir_rows[18] = row(CODE_REL, 1, 9'h000, 0, 0, 8'h80);
        dir_rows[19] = row(CODE_EXT, 1, 9'h000, 0, 0, 8'h80);
        dir_rows[20] = row(CODE_PAUSE, 1, 9'h000, 0, 0, 8'h80);
        dir_rows[21] = row(CODE_FAKE, 1, 9'h000, 0, 0, 8'h80);
        dir_rows[22] = row(8'hFF, 1, 9'h000, 0, 0, 8'h80);
        dir_rows[23] = row(8'h00, 1, 9'h000, 0, 0, 8'h80);
        dir_rows[24] = row(8'h14, 1, 9'h000, 0, 0, 8'h80);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_byte(dir_rows[i].code, dir_rows[i].typed, dir_rows[i].want);

        while (bytes_sent < RANDOM_ITEMS + 25)
        begin
            steady = (bytes_sent >= 400 && bytes_sent < 700);
            if (!drained && bytes_sent >= DRAIN_AT)
            begin
                drained = 1'b1;
                s_tvalid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_results.size() != 0);
            end
            kind = $urandom_range(0, 99);
            code = pick_code();
            if (kind < 30)
                send_code(code);
            else if (kind < 55)
            begin
                send_code(CODE_REL);
                send_code(code);
            end
            else if (kind < 70)
            begin
                send_code(CODE_EXT);
                send_code(code);
            end
            else if (kind < 85)
            begin
                send_code(CODE_EXT);
                send_code(CODE_REL);
                send_code(code);
            end
            else if (kind < 90)
            begin
                send_code(CODE_PAUSE);
                repeat (PAUSE_SKIP) send_code(CODE_W'($urandom_range(0, 255)));
            end
            else
                send_code(CODE_W'($urandom_range(0, 255)));
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d scan code bytes with prefixes, pause skips and noise;", bytes_sent);
        $display("checked %0d results, %0d of them changed the key map.",
                 results_seen, map_changes);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("** ps2_scancode_key_tracker_core: PASSED **");
        else
            $display("** ps2_scancode_key_tracker_core: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
src/ps2kt_pkg.sv
src/ps2kt_ram.sv
src/ps2_scancode_key_tracker_core.sv
tb/ps2_scancode_key_tracker_core_tb.sv
